>>> rtl/sbil_pkg.sv
// ----------------------------------------------------------------------------
// sbil_pkg
// Shared constants for the serial boot image loader.
// ----------------------------------------------------------------------------
package sbil_pkg;

  localparam logic [31:0] MagicWord   = 32'hbeefcafe;
  localparam logic [31:0] CrcPoly     = 32'hedb88320;
  localparam logic [31:0] CrcInit     = 32'hffffffff;
  localparam logic [31:0] LoadBaseRst = 32'h10000100;

  localparam int unsigned HeaderBytes = 12;

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

endpackage

>>> rtl/sbil_crc_byte.sv
// ----------------------------------------------------------------------------
// sbil_crc_byte
// Reflected CRC-32 update over one byte, all eight bit steps unrolled.
// ----------------------------------------------------------------------------
module sbil_crc_byte
  import sbil_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

>>> rtl/serial_boot_image_loader.sv
// ----------------------------------------------------------------------------
// serial_boot_image_loader
// Magic-word hunt, header capture and payload load with CRC-32 check.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the result side takes transfers,
// and each byte gives exactly one registered result: the phase after the byte,
// a memory write for payload bytes, and on the byte that completes an image the
// done flag, the CRC match, the computed CRC and the entry point. The whole step
// (magic compare, header shift, address add, unrolled byte CRC) sits between the
// loader state and a single result register; a stalled result holds rx_ready_o
// low. The user writes load_base through cfg_we_i/cfg_wdata_i only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module serial_boot_image_loader
  import sbil_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,

  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [31:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [1:0]  phase_o,
  output logic        load_done_o,
  output logic        crc_match_o,
  output logic [31:0] entry_address_o,
  output logic [31:0] computed_crc_o
);

  logic [31:0] load_base_q;
  logic [31:0] magic_window_q, magic_window_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  header_count_q, header_count_d;
  logic [31:0] image_length_q, image_length_d;
  logic [31:0] entry_reg_q, entry_reg_d;
  logic [31:0] expected_crc_q, expected_crc_d;
  logic [31:0] payload_offset_q, payload_offset_d;
  logic [31:0] running_crc_q, running_crc_d;

  logic        out_valid_q;
  logic        wvalid_d, done_d, match_d;
  logic [31:0] waddr_d, entry_d, ccrc_d;
  logic [7:0]  wdata_d;
  logic        wvalid_q, done_q, match_q;
  logic [31:0] waddr_q, entry_q, ccrc_q;
  logic [7:0]  wdata_q;
  logic [1:0]  phase_out_q;

  logic        accept;
  logic [31:0] crc_next;
  logic [31:0] window_next;
  logic [31:0] offset_inc;
  logic [3:0]  count_inc;

  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;

  sbil_crc_byte u_crc (
    .crc_i  (running_crc_q),
    .data_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  assign window_next = {magic_window_q[23:0], rx_byte_i};
  assign offset_inc  = payload_offset_q + 32'd1;
  assign count_inc   = header_count_q + 4'd1;

  always_comb begin
    magic_window_d   = magic_window_q;
    phase_d          = phase_q;
    header_count_d   = header_count_q;
    image_length_d   = image_length_q;
    entry_reg_d      = entry_reg_q;
    expected_crc_d   = expected_crc_q;
    payload_offset_d = payload_offset_q;
    running_crc_d    = running_crc_q;
    wvalid_d = 1'b0;
    waddr_d  = '0;
    wdata_d  = '0;
    done_d   = 1'b0;
    match_d  = 1'b0;
    entry_d  = '0;
    ccrc_d   = '0;

    unique case (phase_q)
      PhHeader: begin
        if (header_count_q < 4'd4) begin
          image_length_d = {image_length_q[23:0], rx_byte_i};
        end else if (header_count_q < 4'd8) begin
          entry_reg_d = {entry_reg_q[23:0], rx_byte_i};
        end else begin
          expected_crc_d = {expected_crc_q[23:0], rx_byte_i};
        end
        header_count_d = count_inc;
        if (count_inc >= 4'(HeaderBytes)) begin
          header_count_d   = '0;
          payload_offset_d = '0;
          running_crc_d    = CrcInit;
          if (image_length_d == '0) begin
            done_d  = 1'b1;
            match_d = (expected_crc_d == '0);
            entry_d = entry_reg_d;
            phase_d = PhHunt;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        wvalid_d         = 1'b1;
        waddr_d          = load_base_q + payload_offset_q;
        wdata_d          = rx_byte_i;
        running_crc_d    = crc_next;
        payload_offset_d = offset_inc;
        if (offset_inc == image_length_q) begin
          done_d           = 1'b1;
          ccrc_d           = ~crc_next;
          match_d          = (~crc_next == expected_crc_q);
          entry_d          = entry_reg_q;
          phase_d          = PhHunt;
          running_crc_d    = CrcInit;
          payload_offset_d = '0;
        end
      end
      default: begin
        // hunting; the unused code behaves the same
        phase_d        = PhHunt;
        magic_window_d = window_next;
        if (window_next == MagicWord) begin
          magic_window_d = '0;
          phase_d        = PhHeader;
          header_count_d = '0;
          image_length_d = '0;
          entry_reg_d    = '0;
          expected_crc_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_base_q      <= LoadBaseRst;
      magic_window_q   <= '0;
      phase_q          <= PhHunt;
      header_count_q   <= '0;
      image_length_q   <= '0;
      entry_reg_q      <= '0;
      expected_crc_q   <= '0;
      payload_offset_q <= '0;
      running_crc_q    <= CrcInit;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        load_base_q <= cfg_wdata_i;
      end
      if (accept) begin
        magic_window_q   <= magic_window_d;
        phase_q          <= phase_d;
        header_count_q   <= header_count_d;
        image_length_q   <= image_length_d;
        entry_reg_q      <= entry_reg_d;
        expected_crc_q   <= expected_crc_d;
        payload_offset_q <= payload_offset_d;
        running_crc_q    <= running_crc_d;
        out_valid_q      <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wvalid_q    <= wvalid_d;
      waddr_q     <= waddr_d;
      wdata_q     <= wdata_d;
      phase_out_q <= phase_d;
      done_q      <= done_d;
      match_q     <= match_d;
      entry_q     <= entry_d;
      ccrc_q      <= ccrc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_valid_o   = wvalid_q;
  assign write_address_o = waddr_q;
  assign write_data_o    = wdata_q;
  assign phase_o         = phase_out_q;
  assign load_done_o     = done_q;
  assign crc_match_o     = match_q;
  assign entry_address_o = entry_q;
  assign computed_crc_o  = ccrc_q;

endmodule

>>> tb/sbil_tb_pkg.sv
// ----------------------------------------------------------------------------
// sbil_tb_pkg
// Result prediction and checking for the serial boot image loader bench.
// ----------------------------------------------------------------------------
// Tracks the loader state byte by byte (magic hunt, header capture, payload
// writes with a reflected CRC-32) and queues one predicted result per
// accepted byte. Each result taken from the block is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
package sbil_tb_pkg;
  import sbil_pkg::*;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  phase;
    logic        load_done;
    logic        crc_match;
    logic [31:0] entry_address;
    logic [31:0] computed_crc;
  } loader_result_t;

  // Reflected CRC-32, one byte, bit-serial.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  class image_load_scoreboard;
    logic [31:0]    load_base;
    logic [31:0]    magic_window;
    logic [1:0]     loader_phase;
    logic [3:0]     header_count;
    logic [31:0]    image_length;
    logic [31:0]    entry_point;
    logic [31:0]    header_crc;
    logic [31:0]    payload_offset;
    logic [31:0]    running_crc;
    loader_result_t predicted_results[$];
    int unsigned    error_count;
    int unsigned    result_count;

    function new();
      load_base      = LoadBaseRst;
      magic_window   = '0;
      loader_phase   = PhHunt;
      header_count   = '0;
      image_length   = '0;
      entry_point    = '0;
      header_crc     = '0;
      payload_offset = '0;
      running_crc    = CrcInit;
      error_count    = 0;
      result_count   = 0;
    endfunction

    function void set_load_base(logic [31:0] value);
      load_base = value;
    endfunction

    function int unsigned pending();
      return predicted_results.size();
    endfunction

    // Advance the loader by one accepted byte and queue the result it gives.
    function void note_byte(logic [7:0] rx);
      loader_result_t r;
      logic [31:0]    final_crc;
      r = '0;
      case (loader_phase)
        PhHeader: begin
          if (header_count < 4) begin
            image_length = {image_length[23:0], rx};
          end else if (header_count < 8) begin
            entry_point = {entry_point[23:0], rx};
          end else begin
            header_crc = {header_crc[23:0], rx};
          end
          header_count = header_count + 4'd1;
          if (header_count >= HeaderBytes) begin
            header_count   = '0;
            payload_offset = '0;
            running_crc    = CrcInit;
            if (image_length == 0) begin
              // empty image completes on the last header byte, CRC of nothing is 0
              r.load_done     = 1'b1;
              r.crc_match     = (header_crc == 32'h0);
              r.entry_address = entry_point;
              loader_phase    = PhHunt;
            end else begin
              loader_phase = PhPayload;
            end
          end
        end
        PhPayload: begin
          r.write_valid   = 1'b1;
          r.write_address = load_base + payload_offset;
          r.write_data    = rx;
          running_crc     = crc32_byte(running_crc, rx);
          payload_offset  = payload_offset + 32'd1;
          if (payload_offset == image_length) begin
            final_crc       = ~running_crc;
            r.load_done     = 1'b1;
            r.computed_crc  = final_crc;
            r.crc_match     = (final_crc == header_crc);
            r.entry_address = entry_point;
            loader_phase    = PhHunt;
            running_crc     = CrcInit;
            payload_offset  = '0;
          end
        end
        default: begin
          loader_phase = PhHunt;
          magic_window = {magic_window[23:0], rx};
          if (magic_window == MagicWord) begin
            // clear the window so the next hunt starts empty
            magic_window = '0;
            loader_phase = PhHeader;
            header_count = '0;
            image_length = '0;
            entry_point  = '0;
            header_crc   = '0;
          end
        end
      endcase
      r.phase = loader_phase;
      predicted_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] %s", $time, msg);
      error_count++;
    endtask

    task compare_field(string field, logic [31:0] seen, logic [31:0] want);
      if (seen !== want) begin
        report($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                         result_count, field, seen, want));
      end
    endtask

    task check_result(loader_result_t seen);
      loader_result_t want;
      result_count++;
      if (predicted_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing predicted", result_count));
        return;
      end
      want = predicted_results.pop_front();
      compare_field("write_valid",   32'(seen.write_valid),   32'(want.write_valid));
      compare_field("write_address", seen.write_address,      want.write_address);
      compare_field("write_data",    32'(seen.write_data),    32'(want.write_data));
      compare_field("phase",         32'(seen.phase),         32'(want.phase));
      compare_field("load_done",     32'(seen.load_done),     32'(want.load_done));
      compare_field("crc_match",     32'(seen.crc_match),     32'(want.crc_match));
      compare_field("entry_address", seen.entry_address,      want.entry_address);
      compare_field("computed_crc",  seen.computed_crc,       want.computed_crc);
    endtask
  endclass

endpackage

>>> tb/serial_boot_image_loader_tb.sv
// ----------------------------------------------------------------------------
// serial_boot_image_loader_tb
// Self-checking bench for the serial boot image loader.
// ----------------------------------------------------------------------------
// Feeds a short directed byte stream (sliding magic match, empty image with
// extreme entry point), then random boot images: small payloads with good or
// corrupted CRCs, magic fragments and line noise in between, load base
// changes between images and in the middle of a payload. Both channels
// idle at random; every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module serial_boot_image_loader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbil_pkg::*;
  import sbil_tb_pkg::*;

  localparam int unsigned ImageByteTarget = 950;
  localparam int unsigned WatchdogLimit   = 1000;
  localparam int unsigned MaxWait         = 13;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        rx_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_ready_i = 1'b0;

  logic        rx_ready_o;
  logic        out_valid_o;
  logic        write_valid_o;
  logic [31:0] write_address_o;
  logic [7:0]  write_data_o;
  logic [1:0]  phase_o;
  logic        load_done_o;
  logic        crc_match_o;
  logic [31:0] entry_address_o;
  logic [31:0] computed_crc_o;

  image_load_scoreboard sb;
  loader_result_t       observed;
  int unsigned          tx_calm     = 0;
  int unsigned          rx_calm     = 0;
  int unsigned          base_pick   = 0;
  int unsigned          idle_cycles = 0;

  serial_boot_image_loader uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_valid_o   (write_valid_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .phase_o         (phase_o),
    .load_done_o     (load_done_o),
    .crc_match_o     (crc_match_o),
    .entry_address_o (entry_address_o),
    .computed_crc_o  (computed_crc_o)
  );

  assign observed = {write_valid_o, write_address_o, write_data_o, phase_o,
                     load_done_o, crc_match_o, entry_address_o, computed_crc_o};

  always #10 clk_i = ~clk_i;

  // Random wait per item, with occasional runs of back-to-back transfers.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  // Extremes first, random bases afterwards.
  function automatic logic [31:0] next_base();
    logic [31:0] v;
    case (base_pick)
      0:       v = 32'h0;
      1:       v = 32'hffffffff;
      2:       v = 32'hfffffff0;
      3:       v = 32'h80000000;
      default: v = $urandom();
    endcase
    base_pick++;
    return v;
  endfunction

  function automatic void push_word(ref byte_q_t q, input logic [31:0] w);
    q.push_back(w[31:24]);
    q.push_back(w[23:16]);
    q.push_back(w[15:8]);
    q.push_back(w[7:0]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait(tx_calm);
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    sb.note_byte(b);
  endtask

  task automatic send_all(ref byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Hold the input side until every predicted result has been taken.
  task automatic drain_results();
    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_load_base(value);
  endtask

  // Result side: stall at random before each transfer.
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(observed);
  end

  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    byte_q_t     stream;
    byte_q_t     tail;
    logic [31:0] length;
    logic [31:0] entry;
    logic [31:0] crc;
    logic [7:0]  b;
    int unsigned image_bytes;
    int unsigned cut;
    int unsigned frag;

    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Partial magic restarts inside the window, then an empty image with
    // all-ones entry point and zero CRC. Reset load base stays in place.
    stream = '{8'h00, 8'hff, 8'hbe, 8'hef};
    push_word(stream, MagicWord);
    push_word(stream, 32'h0);
    push_word(stream, 32'hffffffff);
    push_word(stream, 32'h0);
    send_all(stream);
    drain_results();
    write_base(next_base());

    image_bytes = 0;
    while (image_bytes < ImageByteTarget) begin
      stream = {};
      tail   = {};
      if ($urandom_range(0, 9) < 2) begin
        // broken magic: a correct prefix, then a wrong byte and some noise
        frag = $urandom_range(0, 3);
        for (int i = 0; i < frag; i++) stream.push_back(8'(MagicWord >> (24 - 8 * i)));
        b = 8'(MagicWord >> (24 - 8 * frag));
        stream.push_back(b ^ 8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 4)) stream.push_back(8'($urandom()));
        send_all(stream);
      end else begin
        // tail of the magic word must not match against a stale window
        if ($urandom_range(0, 3) == 0) begin
          frag = $urandom_range(1, 3);
          for (int i = 4 - frag; i < 4; i++) stream.push_back(8'(MagicWord >> (24 - 8 * i)));
        end
        case ($urandom_range(0, 15))
          0:          length = 32'd0;
          12, 13, 14: length = $urandom_range(9, 40);
          15:         length = $urandom_range(41, 96);
          default:    length = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 5))
          0:       entry = 32'h0;
          1:       entry = 32'hffffffff;
          default: entry = $urandom();
        endcase
        crc = CrcInit;
        for (int i = 0; i < length; i++) begin
          b = 8'($urandom());
          tail.push_back(b);
          crc = crc32_byte(crc, b);
        end
        crc = ~crc;
        if ($urandom_range(0, 3) == 0) crc = $urandom();
        push_word(stream, MagicWord);
        push_word(stream, length);
        push_word(stream, entry);
        push_word(stream, crc);
        // split some payloads around a load base change
        cut = (length >= 2 && $urandom_range(0, 7) == 0) ? $urandom_range(1, length - 1) : 0;
        for (int i = 0; i < cut; i++) stream.push_back(tail.pop_front());
        send_all(stream);
        if (cut != 0) begin
          drain_results();
          write_base(next_base());
        end
        send_all(tail);
        image_bytes += 16 + length;
        if ($urandom_range(0, 9) == 0) begin
          drain_results();
          write_base(next_base());
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sbil_pkg.sv
rtl/sbil_crc_byte.sv
rtl/serial_boot_image_loader.sv
tb/sbil_tb_pkg.sv
tb/serial_boot_image_loader_tb.sv
